/* rtl/lfxlms_pkg.sv */
// Shared types and constants for the leaky filtered-x LMS adaptive FIR core.
package lfxlms_pkg;

    localparam int DEFAULT_TAP_COUNT = 128;
    localparam int SAMPLE_W          = 16;
    localparam int WEIGHT_W          = 32;
    localparam int LEAK_W            = 16;
    localparam logic [LEAK_W-1:0] LEAK_RESET = 16'hFFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the input word
        logic load;      // write delay lines, form mu*error, clear accumulator
        logic issue;     // read one tap and advance the tap counter
        logic finish;    // round and saturate the output, advance position
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_tap;  // tap counter points at the final tap
    } status_t;

endpackage

/* rtl/lfxlms_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
module lfxlms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/lfxlms_ctrl.sv */
// Sequencer for one sample: load, tap sweep, pipeline drain, output.
module lfxlms_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output lfxlms_pkg::cmd_t    cmd,
    input  lfxlms_pkg::status_t status
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_SWEEP  = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    // Read, multiply and update stages behind the last issued tap.
    localparam logic [1:0] DRAIN_LAST = 2'd2;

    logic [2:0] state_reg, state_next;
    logic [1:0] drain_reg, drain_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        drain_next     = drain_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                cmd.issue = 1'b1;
                if (status.last_tap)
                begin
                    drain_next = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + 2'd1;
                if (drain_reg == DRAIN_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold the result until the output register is free
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            drain_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == ST_LOAD)
        else $error("accepted word did not start a load");

    a_last_tap_drains: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SWEEP && status.last_tap |=> state_reg == ST_DRAIN)
        else $error("sweep did not stop at the last tap");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !out_valid_reg || m_tready)
        else $error("result overwritten before it was taken");

    a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("output valid raised outside finish");

endmodule

/* rtl/lfxlms_datapath.sv */
// Delay lines, weight memory, multiply pipeline, accumulator and output rounding.
module lfxlms_datapath #(
    parameter int TAP_COUNT = lfxlms_pkg::DEFAULT_TAP_COUNT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lfxlms_pkg::cmd_t                     cmd,
    output lfxlms_pkg::status_t                  status,
    input  logic signed [lfxlms_pkg::SAMPLE_W-1:0] ref_sample,
    input  logic signed [lfxlms_pkg::SAMPLE_W-1:0] filtered_ref_sample,
    input  logic signed [lfxlms_pkg::SAMPLE_W-1:0] error_sample,
    input  logic [lfxlms_pkg::LEAK_W-1:0]        step_size,
    input  logic                                 cfg_we,
    input  logic [lfxlms_pkg::LEAK_W-1:0]        cfg_wdata,
    output logic signed [lfxlms_pkg::SAMPLE_W-1:0] anti_noise
);

    localparam int ADDR_W = $clog2(TAP_COUNT);
    localparam int SW     = lfxlms_pkg::SAMPLE_W;
    localparam int WW     = lfxlms_pkg::WEIGHT_W;
    localparam int LW     = lfxlms_pkg::LEAK_W;
    localparam int G_W    = LW + 1 + SW;          // mu * error
    localparam int WX_W   = WW + SW;              // weight * reference
    localparam int LWP_W  = LW + 1 + WW;          // leak * weight
    localparam int GX_W   = G_W + SW;             // mu * error * filtered ref
    localparam int T_W    = LWP_W + 7;            // leak*w*64 - g*xf
    localparam int R_W    = T_W - 22;             // rounded to Q7.24
    localparam int ACC_W  = WX_W + ADDR_W + 1;
    localparam int Y_W    = ACC_W - 24;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TAP_COUNT - 1);
    localparam logic [ADDR_W:0]   DEPTH_W   = (ADDR_W + 1)'(TAP_COUNT);
    localparam logic signed [R_W-1:0] W_MAX = R_W'(64'sd1073741824);
    localparam logic signed [R_W-1:0] W_MIN = R_W'(-64'sd1073741824);
    localparam logic signed [Y_W-1:0] Y_MAX = Y_W'(64'sd32767);
    localparam logic signed [Y_W-1:0] Y_MIN = Y_W'(-64'sd32768);

    // control state
    logic [LW-1:0]     leak_reg;
    logic [ADDR_W-1:0] pos_reg;
    logic              hist_full_reg;
    logic              weights_live_reg;
    logic [ADDR_W-1:0] k_reg;
    logic              v1_reg, v2_reg, v3_reg;

    // payload
    logic signed [SW-1:0]    x_reg, xf_reg, err_reg;
    logic [LW-1:0]           mu_reg;
    logic signed [G_W-1:0]   g_reg;
    logic [ADDR_W-1:0]       k1_reg, k2_reg, k3_reg;
    logic                    hv1_reg;
    logic signed [WX_W-1:0]  prod_wx_reg;
    logic signed [LWP_W-1:0] prod_lw_reg;
    logic signed [GX_W-1:0]  prod_gx_reg;
    logic signed [WW-1:0]    wnew_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [SW-1:0]    out_reg;

    // tap address into the delay lines
    logic [ADDR_W:0]   j_wide;
    logic [ADDR_W-1:0] hist_addr;
    logic              hist_valid;
    logic [ADDR_W-1:0] hist_raddr;

    always_comb
    begin
        if (pos_reg >= k_reg)
        begin
            j_wide = {1'b0, pos_reg} - {1'b0, k_reg};
        end
        else
        begin
            j_wide = {1'b0, pos_reg} + DEPTH_W - {1'b0, k_reg};
        end
    end

    assign hist_addr  = j_wide[ADDR_W-1:0];
    assign hist_valid = hist_full_reg || (pos_reg >= k_reg);
    assign hist_raddr = hist_addr;

    logic [WW-1:0] w_rdata;
    logic [SW-1:0] ref_rdata, fref_rdata;

    lfxlms_ram #(.WIDTH(WW), .DEPTH(TAP_COUNT)) u_weights (
        .clk   (clk),
        .we    (v3_reg),
        .waddr (k3_reg),
        .wdata (wnew_reg),
        .re    (cmd.issue),
        .raddr (k_reg),
        .rdata (w_rdata)
    );

    lfxlms_ram #(.WIDTH(SW), .DEPTH(TAP_COUNT)) u_ref_hist (
        .clk   (clk),
        .we    (cmd.load),
        .waddr (pos_reg),
        .wdata (x_reg),
        .re    (cmd.issue),
        .raddr (hist_raddr),
        .rdata (ref_rdata)
    );

    lfxlms_ram #(.WIDTH(SW), .DEPTH(TAP_COUNT)) u_fref_hist (
        .clk   (clk),
        .we    (cmd.load),
        .waddr (pos_reg),
        .wdata (xf_reg),
        .re    (cmd.issue),
        .raddr (hist_raddr),
        .rdata (fref_rdata)
    );

    // stage 1: mask unwritten entries, multiply
    logic signed [WW-1:0] w_sel;
    logic signed [SW-1:0] x_sel, xf_sel;

    assign w_sel  = weights_live_reg ? $signed(w_rdata) : '0;
    assign x_sel  = hv1_reg ? $signed(ref_rdata) : '0;
    assign xf_sel = hv1_reg ? $signed(fref_rdata) : '0;

    // stage 2: leak and correction, round half up, clamp
    logic signed [T_W-1:0] t_val;
    logic signed [T_W-1:0] t_rnd;
    logic signed [R_W-1:0] w_rnd;
    logic signed [WW-1:0]  w_clamped;

    assign t_val = (T_W'(prod_lw_reg) <<< 6) - T_W'(prod_gx_reg);
    assign t_rnd = t_val + (T_W'(1) <<< 21);
    assign w_rnd = t_rnd[T_W-1:22];

    always_comb
    begin
        if (w_rnd > W_MAX)
        begin
            w_clamped = WW'(W_MAX);
        end
        else if (w_rnd < W_MIN)
        begin
            w_clamped = WW'(W_MIN);
        end
        else
        begin
            w_clamped = WW'(w_rnd);
        end
    end

    // output rounding and saturation
    logic signed [ACC_W-1:0] y_rnd;
    logic signed [Y_W-1:0]   y_val;
    logic signed [SW-1:0]    y_sat;

    assign y_rnd = acc_reg + (ACC_W'(1) <<< 23);
    assign y_val = y_rnd[ACC_W-1:24];

    always_comb
    begin
        if (y_val > Y_MAX)
        begin
            y_sat = SW'(Y_MAX);
        end
        else if (y_val < Y_MIN)
        begin
            y_sat = SW'(Y_MIN);
        end
        else
        begin
            y_sat = SW'(y_val);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leak_reg         <= lfxlms_pkg::LEAK_RESET;
            pos_reg          <= '0;
            hist_full_reg    <= 1'b0;
            weights_live_reg <= 1'b0;
            k_reg            <= '0;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                leak_reg <= cfg_wdata;
            end
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (cmd.load)
            begin
                k_reg <= '0;
            end
            else if (cmd.issue)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                weights_live_reg <= 1'b1;
                if (pos_reg == LAST_ADDR)
                begin
                    pos_reg       <= '0;
                    hist_full_reg <= 1'b1;
                end
                else
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg   <= ref_sample;
            xf_reg  <= filtered_ref_sample;
            err_reg <= error_sample;
            mu_reg  <= step_size;
        end
        if (cmd.load)
        begin
            g_reg   <= $signed({1'b0, mu_reg}) * err_reg;
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_wx_reg);
        end
        k1_reg      <= k_reg;
        hv1_reg     <= hist_valid;
        prod_wx_reg <= w_sel * x_sel;
        prod_lw_reg <= $signed({1'b0, leak_reg}) * w_sel;
        prod_gx_reg <= g_reg * xf_sel;
        k2_reg      <= k1_reg;
        wnew_reg    <= w_clamped;
        k3_reg      <= k2_reg;
        if (cmd.finish)
        begin
            out_reg <= y_sat;
        end
    end

    assign status.last_tap = (k_reg == LAST_ADDR);
    assign anti_noise      = out_reg;

endmodule

/* rtl/leaky_fxlms_adaptive_fir_core.sv */
// Top level of the leaky filtered-x LMS adaptive FIR core.
//
// One input word carries a reference sample, a filtered-reference sample, an
// error sample (all Q1.15) and a step size mu (Q0.16). The core writes both
// reference samples into circular delay lines at the current position, forms
// the FIR output from the weights as they stood before this word, rounds it
// half up and saturates it to Q1.15, and then replaces every weight (Q7.24)
// by leak*w - mu*error*filtered_ref, rounded and clamped to +/-64.0. Exactly
// one output word leaves per input word. From acceptance to the output
// register a word passes through a load step, a sweep of one tap per cycle
// through the weight and delay-line memory ports, a pipeline drain and an
// output step. The core goes back to idle to take the next word, so it takes
// no new word until the last one has reached the output register. The output
// register lets the next input word in while a result still waits; the core
// holds a finished result back only if the previous one has not been taken.
// Memories need no clearing after reset: a written-once flag covers the
// weights and the fill state of the delay lines covers the history. Write
// leak_factor through cfg_we/cfg_wdata only while the core is idle; it resets
// to 65535.
module leaky_fxlms_adaptive_fir_core #(
    parameter int TAP_COUNT = lfxlms_pkg::DEFAULT_TAP_COUNT
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: leak_factor
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata from bit 0: ref_sample[15:0], filtered_ref_sample[31:16],
    // error_sample[47:32], step_size[63:48]
    input  logic [63:0] s_tdata,
    // output words
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata from bit 0: anti_noise[15:0]
    output logic [15:0] m_tdata
);

    lfxlms_pkg::cmd_t    cmd;
    lfxlms_pkg::status_t status;
    logic signed [15:0]  anti_noise;

    lfxlms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    lfxlms_datapath #(.TAP_COUNT(TAP_COUNT)) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .ref_sample          ($signed(s_tdata[15:0])),
        .filtered_ref_sample ($signed(s_tdata[31:16])),
        .error_sample        ($signed(s_tdata[47:32])),
        .step_size           (s_tdata[63:48]),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .anti_noise          (anti_noise)
    );

    assign m_tdata = anti_noise;

endmodule
